[rtl/assert_macros.svh]
// assertion macros shared by the parser rtl
// depends on a clk and an rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define CBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check of post in the cycle after pre, outside reset
`define CBP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[rtl/cbp_pkg.sv]
// shared types, codes and the crc step of the configuration bitstream parser
// no dependencies
`timescale 1ns / 1ps

package cbp_pkg;

  typedef enum logic [3:0] {
    PH_HUNT      = 4'd0,
    PH_CMD       = 4'd1,
    PH_CMNT_OPEN = 4'd2,
    PH_CMNT      = 4'd3,
    PH_ARG       = 4'd4,
    PH_CRAM      = 4'd5,
    PH_BRAM      = 4'd6,
    PH_TRAIL     = 4'd7,
    PH_STOP      = 4'd8
  } phase_t;

  // event codes
  localparam logic [2:0] EV_CRAM  = 3'd0;
  localparam logic [2:0] EV_BRAM  = 3'd1;
  localparam logic [2:0] EV_CRC   = 3'd2;
  localparam logic [2:0] EV_WAKE  = 3'd3;
  localparam logic [2:0] EV_ERROR = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_END  = 3'd1;
  localparam logic [2:0] ERR_CMD  = 3'd2;
  localparam logic [2:0] ERR_ARG  = 3'd3;
  localparam logic [2:0] ERR_SIZE = 3'd4;

  // command bytes
  localparam logic [7:0] CMD_CTRL    = 8'h01;
  localparam logic [7:0] CMD_BANK    = 8'h11;
  localparam logic [7:0] CMD_CRC     = 8'h22;
  localparam logic [7:0] CMD_FREQ    = 8'h51;
  localparam logic [7:0] CMD_ROW     = 8'h62;
  localparam logic [7:0] CMD_COL     = 8'h72;
  localparam logic [7:0] CMD_PTR     = 8'h82;
  localparam logic [7:0] CMD_BOOT    = 8'h92;
  localparam logic [7:0] CMD_COMMENT = 8'hFF;

  // opcodes
  localparam logic [3:0] OP_CTRL = 4'h0;
  localparam logic [3:0] OP_BANK = 4'h1;
  localparam logic [3:0] OP_CRC  = 4'h2;
  localparam logic [3:0] OP_FREQ = 4'h5;
  localparam logic [3:0] OP_ROW  = 4'h6;
  localparam logic [3:0] OP_COL  = 4'h7;
  localparam logic [3:0] OP_PTR  = 4'h8;

  // control arguments
  localparam logic [31:0] CTL_CRAM   = 32'h01;
  localparam logic [31:0] CTL_BRAM   = 32'h03;
  localparam logic [31:0] CTL_CRCRST = 32'h05;
  localparam logic [31:0] CTL_WAKE   = 32'h06;

  localparam logic [31:0] PREAMBLE     = 32'h7EAA997E;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CMNT_END     = 16'h00FF;
  localparam logic [31:0] BOOT_MASK    = 32'h0000FFDF;
  localparam logic [31:0] PTR_KEEP     = 32'h00000080;
  localparam logic [31:0] BANK_MAX     = 32'd3;
  localparam logic [31:0] FREQ_MAX     = 32'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [FIFO_AW:0] level;
  } front_stat_t;

  typedef struct packed {
    logic stopped;
  } back_stat_t;

  // one byte through the crc, msb first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

[rtl/cbp_front.sv]
// front end: takes stream words and queues them as classified items
// depends on cbp_pkg
`timescale 1ns / 1ps

module cbp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] in_byte
  input  logic               in_tuser,   // [0] stream_end
  output logic               item_valid,
  output cbp_pkg::item_t     item,
  input  logic               item_take,
  output cbp_pkg::front_stat_t stat
);

  cbp_pkg::item_t                  mem [cbp_pkg::FIFO_DEPTH];
  logic [cbp_pkg::FIFO_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [cbp_pkg::FIFO_AW:0]       level_r;
  logic                            push, pop;

  assign in_tready  = (level_r != (cbp_pkg::FIFO_AW+1)'(cbp_pkg::FIFO_DEPTH));
  assign push       = in_tvalid && in_tready;
  assign item_valid = (level_r != '0);
  assign pop        = item_take && item_valid;
  assign item       = mem[rd_ptr_r];
  assign stat.level = level_r;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= '{is_end: in_tuser, data: in_tdata};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      level_r <= level_r + 1'b1;
      else if (pop && !push) level_r <= level_r - 1'b1;
    end
  end

endmodule

[rtl/cbp_back.sv]
// back end: command decoder, crc and write sequencer with output register
// depends on cbp_pkg
`timescale 1ns / 1ps

module cbp_back #(
  parameter int ADDR_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  cbp_pkg::item_t      item,
  output logic                item_take,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,
  output logic [2:0]          out_tuser,
  output cbp_pkg::back_stat_t stat
);

  localparam logic [31:0] LIMIT = 32'd1 << ADDR_WIDTH;

  cbp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt, saved_r, saved_nxt;
  logic [31:0] win_r, win_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [3:0]  pend_r, pend_nxt;
  logic [1:0]  bank_r, bank_nxt, freq_r, freq_nxt;
  logic        boot_r, boot_nxt;
  logic [16:0] crow_r, crow_nxt, brow_r, brow_nxt;
  logic [15:0] ccol_r, ccol_nxt, bcol_r, bcol_nxt;
  logic [ADDR_WIDTH:0]   ptr_r, ptr_nxt, rem_r, rem_nxt;
  logic [ADDR_WIDTH-1:0] idx_r, idx_nxt;
  logic [32:0] cprod_r, bprod_r;

  logic        ov_r, ov_nxt, om_r, om_nxt;
  logic [2:0]  oev_r, oev_nxt, oerr_r, oerr_nxt;
  logic [15:0] oaddr_r, oaddr_nxt;
  logic [7:0]  odat_r, odat_nxt;

  logic        take, live;
  logic [7:0]  b;
  logic [31:0] arg, n_c, n_b, ptr_sum, wr_n;
  logic [3:0]  op;
  logic        last_arg, cmd_ok, cram_big, bram_big;
  logic        ex_err3, ex_err4, ex_wake, wr_cram, wr_bram, wr_zero;

  assign take      = item_valid && (!ov_r || out_tready);
  assign item_take = take;
  assign live      = take && (phase_r != cbp_pkg::PH_STOP);
  assign b         = item.data;
  assign arg       = {win_r[23:0], b};
  assign op        = cmd_r[7:4];
  assign last_arg  = (pend_r == 4'd1);

  // byte counts from registered products
  assign n_c     = {2'b00, cprod_r[32:3]};
  assign n_b     = {2'b00, bprod_r[32:3]};
  assign ptr_sum = 32'(ptr_r) + n_b;

  // command decode and argument checks
  always_comb begin
    cmd_ok   = (b inside {cbp_pkg::CMD_CTRL, cbp_pkg::CMD_BANK, cbp_pkg::CMD_CRC,
                          cbp_pkg::CMD_FREQ, cbp_pkg::CMD_ROW, cbp_pkg::CMD_COL,
                          cbp_pkg::CMD_PTR, cbp_pkg::CMD_BOOT});
    cram_big = (n_c > LIMIT);
    bram_big = (n_b > LIMIT) || (ptr_sum > LIMIT);
    ex_err3  = 1'b0;
    ex_err4  = 1'b0;
    ex_wake  = 1'b0;
    wr_cram  = 1'b0;
    wr_bram  = 1'b0;
    case (op)
      cbp_pkg::OP_CTRL: begin
        ex_err3 = !(arg inside {cbp_pkg::CTL_CRAM, cbp_pkg::CTL_BRAM,
                                cbp_pkg::CTL_CRCRST, cbp_pkg::CTL_WAKE});
        ex_wake = (arg == cbp_pkg::CTL_WAKE);
        ex_err4 = ((arg == cbp_pkg::CTL_CRAM) && cram_big) ||
                  ((arg == cbp_pkg::CTL_BRAM) && bram_big);
        wr_cram = (arg == cbp_pkg::CTL_CRAM) && !cram_big;
        wr_bram = (arg == cbp_pkg::CTL_BRAM) && !bram_big;
      end
      cbp_pkg::OP_BANK: ex_err3 = (arg > cbp_pkg::BANK_MAX);
      cbp_pkg::OP_FREQ: ex_err3 = (arg > cbp_pkg::FREQ_MAX);
      cbp_pkg::OP_PTR:  ex_err3 = (arg != '0) && (arg != cbp_pkg::PTR_KEEP);
      cbp_pkg::OP_CRC, cbp_pkg::OP_ROW, cbp_pkg::OP_COL: ex_err3 = 1'b0;
      default:          ex_err3 = ((arg & cbp_pkg::BOOT_MASK) != '0);
    endcase
    wr_n    = wr_bram ? n_b : n_c;
    wr_zero = (wr_n == '0);
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (live) begin
      if (item.is_end) begin
        phase_nxt = cbp_pkg::PH_STOP;
      end else begin
        case (phase_r)
          cbp_pkg::PH_HUNT: begin
            if (arg == cbp_pkg::PREAMBLE) phase_nxt = cbp_pkg::PH_CMD;
          end
          cbp_pkg::PH_CMD: begin
            if (b == cbp_pkg::CMD_COMMENT) phase_nxt = cbp_pkg::PH_CMNT_OPEN;
            else if (!cmd_ok)              phase_nxt = cbp_pkg::PH_STOP;
            else                           phase_nxt = cbp_pkg::PH_ARG;
          end
          cbp_pkg::PH_CMNT_OPEN: begin
            phase_nxt = (b != 8'h00) ? cbp_pkg::PH_STOP : cbp_pkg::PH_CMNT;
          end
          cbp_pkg::PH_CMNT: begin
            if (arg[15:0] == cbp_pkg::CMNT_END) phase_nxt = cbp_pkg::PH_CMD;
          end
          cbp_pkg::PH_ARG: begin
            if (last_arg) begin
              if (ex_err3 || ex_err4 || ex_wake) phase_nxt = cbp_pkg::PH_STOP;
              else if ((wr_cram || wr_bram) && wr_zero) phase_nxt = cbp_pkg::PH_TRAIL;
              else if (wr_cram) phase_nxt = cbp_pkg::PH_CRAM;
              else if (wr_bram) phase_nxt = cbp_pkg::PH_BRAM;
              else              phase_nxt = cbp_pkg::PH_CMD;
            end
          end
          cbp_pkg::PH_CRAM, cbp_pkg::PH_BRAM: begin
            if (rem_r == (ADDR_WIDTH+1)'(1)) phase_nxt = cbp_pkg::PH_TRAIL;
          end
          cbp_pkg::PH_TRAIL: begin
            if (pend_r == 4'd1) phase_nxt = cbp_pkg::PH_CMD;
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // datapath and result word
  always_comb begin
    crc_nxt = crc_r;   saved_nxt = saved_r; win_nxt = win_r;  cmd_nxt = cmd_r;
    pend_nxt = pend_r; bank_nxt = bank_r;   freq_nxt = freq_r; boot_nxt = boot_r;
    crow_nxt = crow_r; ccol_nxt = ccol_r;   brow_nxt = brow_r; bcol_nxt = bcol_r;
    ptr_nxt = ptr_r;   rem_nxt = rem_r;     idx_nxt = idx_r;
    ov_nxt = ov_r && !out_tready;
    oev_nxt = oev_r; oerr_nxt = oerr_r; om_nxt = om_r; oaddr_nxt = oaddr_r;
    odat_nxt = odat_r;
    if (take) begin
      ov_nxt    = 1'b0;
      oev_nxt   = cbp_pkg::EV_ERROR;
      oerr_nxt  = cbp_pkg::ERR_NONE;
      om_nxt    = 1'b0;
      oaddr_nxt = '0;
      odat_nxt  = '0;
    end
    if (live) begin
      if (item.is_end) begin
        ov_nxt   = 1'b1;
        oerr_nxt = cbp_pkg::ERR_END;
      end else begin
        crc_nxt = cbp_pkg::crc_step(crc_r, b);
        case (phase_r)
          cbp_pkg::PH_HUNT: win_nxt = arg;
          cbp_pkg::PH_CMD: begin
            saved_nxt = crc_r;
            cmd_nxt   = b;
            if (b != cbp_pkg::CMD_COMMENT) begin
              if (!cmd_ok) begin
                ov_nxt   = 1'b1;
                oerr_nxt = cbp_pkg::ERR_CMD;
              end else begin
                pend_nxt = b[3:0];
                win_nxt  = '0;
              end
            end
          end
          cbp_pkg::PH_CMNT_OPEN: begin
            if (b != 8'h00) begin
              ov_nxt   = 1'b1;
              oerr_nxt = cbp_pkg::ERR_ARG;
            end else begin
              win_nxt = '0;
            end
          end
          cbp_pkg::PH_CMNT: win_nxt = arg;
          cbp_pkg::PH_ARG: begin
            win_nxt  = arg;
            pend_nxt = pend_r - 4'd1;
            if (last_arg) begin
              if (ex_err3) begin
                ov_nxt   = 1'b1;
                oerr_nxt = cbp_pkg::ERR_ARG;
              end else if (ex_err4) begin
                ov_nxt   = 1'b1;
                oerr_nxt = cbp_pkg::ERR_SIZE;
              end else begin
                case (op)
                  cbp_pkg::OP_CTRL: begin
                    if (ex_wake) begin
                      ov_nxt  = 1'b1;
                      oev_nxt = cbp_pkg::EV_WAKE;
                    end
                    if (arg == cbp_pkg::CTL_CRCRST) crc_nxt = '0;
                    if (wr_cram || wr_bram) begin
                      rem_nxt = (ADDR_WIDTH+1)'(wr_n);
                      idx_nxt = wr_bram ? ptr_r[ADDR_WIDTH-1:0] : '0;
                      if (wr_zero) pend_nxt = 4'd2;
                    end
                  end
                  cbp_pkg::OP_BANK: bank_nxt = arg[1:0];
                  cbp_pkg::OP_CRC: begin
                    ov_nxt  = 1'b1;
                    oev_nxt = cbp_pkg::EV_CRC;
                    om_nxt  = (arg[15:0] == saved_r);
                  end
                  cbp_pkg::OP_FREQ: freq_nxt = arg[1:0];
                  cbp_pkg::OP_ROW: begin
                    if (crow_r != '0) brow_nxt = 17'(arg[15:0]) + 17'd1;
                    else              crow_nxt = 17'(arg[15:0]) + 17'd1;
                  end
                  cbp_pkg::OP_COL: begin
                    if (ccol_r != '0) bcol_nxt = arg[15:0];
                    else              ccol_nxt = arg[15:0];
                  end
                  cbp_pkg::OP_PTR: begin
                    if (arg == '0) ptr_nxt = '0;
                  end
                  default: boot_nxt = arg[5];
                endcase
              end
            end
          end
          cbp_pkg::PH_CRAM, cbp_pkg::PH_BRAM: begin
            ov_nxt    = 1'b1;
            oev_nxt   = (phase_r == cbp_pkg::PH_BRAM) ? cbp_pkg::EV_BRAM : cbp_pkg::EV_CRAM;
            oaddr_nxt = 16'(idx_r);
            odat_nxt  = b;
            idx_nxt   = idx_r + 1'b1;
            rem_nxt   = rem_r - 1'b1;
            if (phase_r == cbp_pkg::PH_BRAM) ptr_nxt = ptr_r + 1'b1;
            if (rem_r == (ADDR_WIDTH+1)'(1)) pend_nxt = 4'd2;
          end
          cbp_pkg::PH_TRAIL: pend_nxt = pend_r - 4'd1;
          default: pend_nxt = pend_r;
        endcase
      end
    end
  end

  // frame size products, registered from the size registers
  always_ff @(posedge clk) begin
    cprod_r <= 33'(ccol_r) * 33'(crow_r);
    bprod_r <= 33'(bcol_r) * 33'(brow_r);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cbp_pkg::PH_HUNT;
      crc_r <= '0; saved_r <= '0; win_r <= '0; cmd_r <= '0; pend_r <= '0;
      bank_r <= '0; freq_r <= '0; boot_r <= 1'b0;
      crow_r <= '0; ccol_r <= '0; brow_r <= '0; bcol_r <= '0;
      ptr_r <= '0; rem_r <= '0; idx_r <= '0;
      ov_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      crc_r <= crc_nxt; saved_r <= saved_nxt; win_r <= win_nxt; cmd_r <= cmd_nxt;
      pend_r <= pend_nxt; bank_r <= bank_nxt; freq_r <= freq_nxt; boot_r <= boot_nxt;
      crow_r <= crow_nxt; ccol_r <= ccol_nxt; brow_r <= brow_nxt; bcol_r <= bcol_nxt;
      ptr_r <= ptr_nxt; rem_r <= rem_nxt; idx_r <= idx_nxt;
      ov_r <= ov_nxt;
    end
  end

  // result word payload, with the mode fields as they stood at emission
  logic [1:0] obank_r, ofreq_r;
  logic       oboot_r;
  always_ff @(posedge clk) begin
    oev_r <= oev_nxt; oerr_r <= oerr_nxt; om_r <= om_nxt;
    oaddr_r <= oaddr_nxt; odat_r <= odat_nxt;
    if (take) begin
      obank_r <= bank_r;
      ofreq_r <= freq_r;
      oboot_r <= boot_r;
    end
  end

  assign out_tvalid   = ov_r;
  assign out_tuser    = oev_r;
  assign out_tdata    = {7'b0, oboot_r, ofreq_r, oerr_r, om_r, odat_r, oaddr_r, obank_r};
  assign stat.stopped = (phase_r == cbp_pkg::PH_STOP);

endmodule

[rtl/config_bitstream_parser.sv]
// Configuration bitstream parser, top level.
// Input stream: one word per configuration byte, in_tdata carries the byte and
// in_tuser marks the end of the source (such a word carries no byte). Every
// byte feeds a crc-16 (0x1021, msb first); the parser hunts for the preamble,
// skips comments and decodes bank, frequency, size, pointer, boot, crc and
// data-write commands.
// Output stream: at most one word per input word: cram/bram data bytes with
// their address, crc check results, wake-up and errors (event in out_tuser).
// Throughput: one word per cycle while the receiver takes every result. A word
// is written into a four-entry queue, then passes the decoder, and its result
// word is registered in the output register. The frame size products are
// registered from the size registers, ahead of any write that uses them.
// Reset clears the queue, the parser state and the output valid flag; the
// parser then hunts for the preamble. After wake-up or an error the parser
// swallows all further words until reset. When the receiver stalls, the
// result is held and the queue fills, dropping in_tready once it is full.
// depends on cbp_pkg, cbp_front, cbp_back, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module config_bitstream_parser #(
  parameter int ADDR_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] bank, [17:2] address, [25:18] data_out, [26] crc_match,
  // [29:27] error_code, [31:30] freq_setting, [32] warmboot
  output logic [39:0] out_tdata,
  output logic [2:0]  out_tuser   // [2:0] event_res
);

  logic                  item_valid, item_take;
  cbp_pkg::item_t        item;
  cbp_pkg::front_stat_t  fstat;
  cbp_pkg::back_stat_t   bstat;

  // input queue
  cbp_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .item_valid, .item, .item_take, .stat(fstat)
  );

  // parser
  cbp_back #(.ADDR_WIDTH(ADDR_WIDTH)) u_back (
    .clk, .rst_n, .item_valid, .item, .item_take,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .stat(bstat)
  );

  `CBP_ASSERT(a_level, fstat.level <= (cbp_pkg::FIFO_AW+1)'(cbp_pkg::FIFO_DEPTH), "queue overfilled")
  `CBP_ASSERT_NEXT(a_quiet, bstat.stopped && !out_tvalid, !out_tvalid, "word after stop")
  `CBP_ASSERT(a_stop, out_tvalid && (out_tuser == cbp_pkg::EV_ERROR || out_tuser == cbp_pkg::EV_WAKE) |-> bstat.stopped, "no stop after final event")

endmodule

[tb/tb_config_bitstream_parser.sv]
// self-checking testbench for the configuration bitstream parser
// builds a legal command stream with random content, predicts every result
// word, and ends in one stopping case. depends on cbp_pkg and the parser rtl
`timescale 1ns / 1ps

module tb_config_bitstream_parser;

  typedef struct packed {
    logic [2:0]  ev;
    logic [1:0]  bank;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        match;
    logic [2:0]  err;
    logic [1:0]  freq;
    logic        boot;
  } parse_event_t;

  typedef struct {
    bit       pause;
    bit       is_end;
    bit [7:0] data;
  } stim_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;

  config_bitstream_parser #(.ADDR_WIDTH(16)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #10 clk = ~clk;

  stim_word_t   byte_queue[$];
  parse_event_t expected_events[$];
  int           mismatches = 0;
  int           words_taken = 0;
  int           events_seen = 0;
  bit           calm_mode = 1'b0;

  // parser shadow state
  cbp_pkg::phase_t ph;
  logic [15:0] crc_q, saved_crc;
  logic [31:0] window;
  logic [7:0]  cmd_q;
  logic [3:0]  pend;
  logic [1:0]  bank_q, freq_q;
  logic        boot_q;
  logic [16:0] c_rows, b_rows, remain, bptr;
  logic [15:0] c_cols, b_cols, idx;

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ 16'h1021;
    end
    return c;
  endfunction

  function automatic parse_event_t make_event(input logic [2:0] ev, input logic [15:0] a,
                                              input logic [7:0] d, input logic m,
                                              input logic [2:0] e);
    parse_event_t r;
    r.ev = ev; r.bank = bank_q; r.addr = a; r.data = d; r.match = m; r.err = e;
    r.freq = freq_q; r.boot = boot_q;
    return r;
  endfunction

  function automatic parse_event_t make_error(input logic [2:0] e);
    return make_event(cbp_pkg::EV_ERROR, 16'd0, 8'd0, 1'b0, e);
  endfunction

  // size check and start of a cram or bram write
  task automatic begin_write(input bit bram, output bit has, output parse_event_t r);
    logic [33:0] n;
    n = bram ? ((b_cols * b_rows) >> 3) : ((c_cols * c_rows) >> 3);
    has = 1'b0;
    if (n > 34'h10000 || (bram && ({17'd0, bptr} + n > 34'h10000))) begin
      ph = cbp_pkg::PH_STOP; has = 1'b1; r = make_error(cbp_pkg::ERR_SIZE);
      return;
    end
    idx    = bram ? bptr[15:0] : 16'd0;
    remain = n[16:0];
    if (n == 0) begin
      ph = cbp_pkg::PH_TRAIL; pend = 4'd2;
    end else begin
      ph = bram ? cbp_pkg::PH_BRAM : cbp_pkg::PH_CRAM;
    end
  endtask

  // command execution once all argument bytes are in
  task automatic run_command(output bit has, output parse_event_t r);
    logic [31:0] arg;
    arg = window;
    ph  = cbp_pkg::PH_CMD;
    has = 1'b0;
    case (cmd_q[7:4])
      cbp_pkg::OP_CTRL: begin
        if (arg == cbp_pkg::CTL_CRAM) begin_write(1'b0, has, r);
        else if (arg == cbp_pkg::CTL_BRAM) begin_write(1'b1, has, r);
        else if (arg == cbp_pkg::CTL_CRCRST) crc_q = '0;
        else if (arg == cbp_pkg::CTL_WAKE) begin
          ph = cbp_pkg::PH_STOP; has = 1'b1;
          r = make_event(cbp_pkg::EV_WAKE, 16'd0, 8'd0, 1'b0, cbp_pkg::ERR_NONE);
        end else begin
          ph = cbp_pkg::PH_STOP; has = 1'b1; r = make_error(cbp_pkg::ERR_ARG);
        end
      end
      cbp_pkg::OP_BANK: begin
        if (arg > cbp_pkg::BANK_MAX) begin
          ph = cbp_pkg::PH_STOP; has = 1'b1; r = make_error(cbp_pkg::ERR_ARG);
        end else bank_q = arg[1:0];
      end
      cbp_pkg::OP_CRC: begin
        has = 1'b1;
        r = make_event(cbp_pkg::EV_CRC, 16'd0, 8'd0, arg[15:0] == saved_crc,
                       cbp_pkg::ERR_NONE);
      end
      cbp_pkg::OP_FREQ: begin
        if (arg > cbp_pkg::FREQ_MAX) begin
          ph = cbp_pkg::PH_STOP; has = 1'b1; r = make_error(cbp_pkg::ERR_ARG);
        end else freq_q = arg[1:0];
      end
      cbp_pkg::OP_ROW: begin
        if (c_rows != 0) b_rows = arg[16:0] + 17'd1;
        else c_rows = arg[16:0] + 17'd1;
      end
      cbp_pkg::OP_COL: begin
        if (c_cols != 0) b_cols = arg[15:0];
        else c_cols = arg[15:0];
      end
      cbp_pkg::OP_PTR: begin
        if (arg == 32'd0) bptr = '0;
        else if (arg != cbp_pkg::PTR_KEEP) begin
          ph = cbp_pkg::PH_STOP; has = 1'b1; r = make_error(cbp_pkg::ERR_ARG);
        end
      end
      default: begin
        if ((arg & cbp_pkg::BOOT_MASK) != 0) begin
          ph = cbp_pkg::PH_STOP; has = 1'b1; r = make_error(cbp_pkg::ERR_ARG);
        end else boot_q = arg[5];
      end
    endcase
  endtask

  // one accepted word through the shadow parser
  task automatic parse_word(input bit is_end, input logic [7:0] b,
                            output bit has, output parse_event_t r);
    logic [15:0] prev;
    logic [15:0] a;
    has  = 1'b0;
    prev = crc_q;
    if (ph == cbp_pkg::PH_STOP) return;
    if (is_end) begin
      ph = cbp_pkg::PH_STOP; has = 1'b1; r = make_error(cbp_pkg::ERR_END);
      return;
    end
    crc_q = crc_next(crc_q, b);
    case (ph)
      cbp_pkg::PH_HUNT: begin
        window = {window[23:0], b};
        if (window == cbp_pkg::PREAMBLE) ph = cbp_pkg::PH_CMD;
      end
      cbp_pkg::PH_CMD: begin
        saved_crc = prev;
        cmd_q = b;
        if (b == cbp_pkg::CMD_COMMENT) ph = cbp_pkg::PH_CMNT_OPEN;
        else if (!(b inside {cbp_pkg::CMD_CTRL, cbp_pkg::CMD_BANK, cbp_pkg::CMD_CRC,
                             cbp_pkg::CMD_FREQ, cbp_pkg::CMD_ROW, cbp_pkg::CMD_COL,
                             cbp_pkg::CMD_PTR, cbp_pkg::CMD_BOOT})) begin
          ph = cbp_pkg::PH_STOP; has = 1'b1; r = make_error(cbp_pkg::ERR_CMD);
        end else begin
          pend = b[3:0]; window = '0; ph = cbp_pkg::PH_ARG;
        end
      end
      cbp_pkg::PH_CMNT_OPEN: begin
        if (b != 0) begin
          ph = cbp_pkg::PH_STOP; has = 1'b1; r = make_error(cbp_pkg::ERR_ARG);
        end else begin
          window = '0; ph = cbp_pkg::PH_CMNT;
        end
      end
      cbp_pkg::PH_CMNT: begin
        window = {window[23:0], b};
        if (window[15:0] == cbp_pkg::CMNT_END) ph = cbp_pkg::PH_CMD;
      end
      cbp_pkg::PH_ARG: begin
        window = {window[23:0], b};
        pend = pend - 4'd1;
        if (pend == 0) run_command(has, r);
      end
      cbp_pkg::PH_CRAM, cbp_pkg::PH_BRAM: begin
        a = idx;
        idx = idx + 16'd1;
        if (ph == cbp_pkg::PH_BRAM) bptr = bptr + 17'd1;
        remain = remain - 17'd1;
        has = 1'b1;
        r = make_event(ph == cbp_pkg::PH_BRAM ? cbp_pkg::EV_BRAM : cbp_pkg::EV_CRAM,
                       a, b, 1'b0, cbp_pkg::ERR_NONE);
        if (remain == 0) begin
          ph = cbp_pkg::PH_TRAIL; pend = 4'd2;
        end
      end
      default: begin
        pend = pend - 4'd1;
        if (pend == 0) ph = cbp_pkg::PH_CMD;
      end
    endcase
  endtask

  // gap lengths: mostly none or short, a few long, calm stretches without any
  function automatic int pick_gap();
    int roll;
    if (calm_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // ---------------------------------------------------------------- stream builder
  logic [15:0] gen_crc = '0;
  int g_crows = 0, g_ccols = 0, g_brows = 0, g_bcols = 0, g_bptr = 0;

  task automatic push_byte(input bit [7:0] b);
    stim_word_t w;
    w.pause = 0; w.is_end = 0; w.data = b;
    byte_queue.push_back(w);
    gen_crc = crc_next(gen_crc, b);
  endtask

  task automatic push_pause();
    stim_word_t w;
    w.pause = 1; w.is_end = 0; w.data = 0;
    byte_queue.push_back(w);
  endtask

  task automatic push_cmd(input bit [7:0] cmd, input bit [15:0] arg);
    push_byte(cmd);
    if (cmd[3:0] == 4'd2) push_byte(arg[15:8]);
    push_byte(arg[7:0]);
    if (cmd == cbp_pkg::CMD_ROW) begin
      if (g_crows != 0) g_brows = arg + 1; else g_crows = arg + 1;
    end
    if (cmd == cbp_pkg::CMD_COL) begin
      if (g_ccols != 0) g_bcols = arg; else g_ccols = arg;
    end
    if (cmd == cbp_pkg::CMD_PTR && arg == 0) g_bptr = 0;
    if (cmd == cbp_pkg::CMD_CTRL && arg == 16'(cbp_pkg::CTL_CRCRST)) gen_crc = '0;
  endtask

  task automatic push_write(input bit bram);
    int n;
    n = bram ? (g_bcols * g_brows) / 8 : (g_ccols * g_crows) / 8;
    if (bram && g_bptr + n > 60000) push_cmd(cbp_pkg::CMD_PTR, 16'h0000);
    push_cmd(cbp_pkg::CMD_CTRL, bram ? 16'(cbp_pkg::CTL_BRAM) : 16'(cbp_pkg::CTL_CRAM));
    repeat (n) push_byte(8'($urandom_range(0, 255)));
    if (bram) g_bptr += n;
    push_byte(8'($urandom_range(0, 255)));
    push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic push_crc_check(input bit good);
    logic [15:0] pre;
    pre = gen_crc;
    push_cmd(cbp_pkg::CMD_CRC, good ? pre : 16'($urandom()));
  endtask

  // comment body never holds 00 followed by ff before its end
  task automatic push_comment(input int len);
    bit [7:0] prev, b;
    push_byte(cbp_pkg::CMD_COMMENT);
    push_byte(8'h00);
    prev = 8'h00;
    repeat (len) begin
      b = 8'($urandom_range(0, 255));
      if (prev == 8'h00 && b == 8'hFF) b = 8'hFE;
      push_byte(b);
      prev = b;
    end
    if (prev != 8'h00) push_byte(8'h00);
    push_byte(8'hFF);
  endtask

  task automatic push_random_command();
    case ($urandom_range(0, 11))
      0: push_cmd(cbp_pkg::CMD_BANK, 16'($urandom_range(0, 3)));
      1: push_cmd(cbp_pkg::CMD_FREQ, 16'($urandom_range(0, 2)));
      2: push_cmd(cbp_pkg::CMD_ROW, 16'($urandom_range(0, 7)));
      3: push_cmd(cbp_pkg::CMD_COL, 16'(8 * $urandom_range(0, 8)));
      4: push_cmd(cbp_pkg::CMD_PTR, $urandom_range(0, 1) ? 16'h0000 : 16'h0080);
      5: push_cmd(cbp_pkg::CMD_BOOT, $urandom_range(0, 1) ? 16'h0020 : 16'h0000);
      6: push_cmd(cbp_pkg::CMD_CTRL, 16'(cbp_pkg::CTL_CRCRST));
      7: push_crc_check($urandom_range(0, 2) != 0);
      8: push_write(1'b0);
      9, 10: push_write(1'b1);
      default: push_comment($urandom_range(0, 6));
    endcase
  endtask

  // the one stop that ends the stream, picked at random among its cases
  task automatic push_ending();
    stim_word_t w;
    bit [7:0] b;
    case ($urandom_range(0, 4))
      0: push_cmd(cbp_pkg::CMD_CTRL, 16'(cbp_pkg::CTL_WAKE));
      1: begin
        w.pause = 0; w.is_end = 1; w.data = 8'($urandom_range(0, 255));
        byte_queue.push_back(w);
      end
      2: begin
        do b = 8'($urandom_range(0, 255));
        while (b inside {cbp_pkg::CMD_CTRL, cbp_pkg::CMD_BANK, cbp_pkg::CMD_CRC,
                         cbp_pkg::CMD_FREQ, cbp_pkg::CMD_ROW, cbp_pkg::CMD_COL,
                         cbp_pkg::CMD_PTR, cbp_pkg::CMD_BOOT, cbp_pkg::CMD_COMMENT});
        push_byte(b);
        push_byte(8'($urandom_range(0, 255)));
      end
      3: begin
        case ($urandom_range(0, 5))
          0: push_cmd(cbp_pkg::CMD_BANK, 16'($urandom_range(4, 255)));
          1: push_cmd(cbp_pkg::CMD_FREQ, 16'($urandom_range(3, 255)));
          2: push_cmd(cbp_pkg::CMD_PTR, 16'h0001);
          3: push_cmd(cbp_pkg::CMD_BOOT, 16'h0040);
          4: push_cmd(cbp_pkg::CMD_CTRL, 16'h0002);
          default: begin
            push_byte(cbp_pkg::CMD_COMMENT);
            push_byte(8'($urandom_range(1, 255)));
          end
        endcase
      end
      default: begin
        push_cmd(cbp_pkg::CMD_ROW, 16'hFFFF);
        push_cmd(cbp_pkg::CMD_COL, 16'hFFFF);
        push_cmd(cbp_pkg::CMD_CTRL, 16'(cbp_pkg::CTL_BRAM));
      end
    endcase
    // words after the stop are swallowed
    repeat (20) begin
      w.pause = 0; w.is_end = 1'($urandom_range(0, 1)); w.data = 8'($urandom_range(0, 255));
      byte_queue.push_back(w);
    end
  endtask

  // ---------------------------------------------------------------- driver
  bit           drv_next;
  bit           drv_has;
  int           drv_gap = 0;
  parse_event_t drv_ev;
  stim_word_t   drv_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      ph = cbp_pkg::PH_HUNT; crc_q = '0; saved_crc = '0; window = '0; cmd_q = '0;
      pend = '0; bank_q = '0; freq_q = '0; boot_q = 1'b0; c_rows = '0; c_cols = '0;
      b_rows = '0; b_cols = '0; bptr = '0; remain = '0; idx = '0;
    end else begin
      drv_next = in_tvalid;
      if (in_tvalid && in_tready) begin
        parse_word(in_tuser, in_tdata, drv_has, drv_ev);
        if (drv_has) expected_events.push_back(drv_ev);
        words_taken++;
        drv_next = 1'b0;
      end
      if (!drv_next) begin
        if (drv_gap > 0) drv_gap--;
        else if (byte_queue.size() > 0) begin
          if (byte_queue[0].pause) begin
            if (expected_events.size() == 0) void'(byte_queue.pop_front());
          end else begin
            drv_word = byte_queue.pop_front();
            in_tdata <= drv_word.data;
            in_tuser <= drv_word.is_end;
            drv_next = 1'b1;
            drv_gap  = pick_gap();
          end
        end
        if ($urandom_range(0, 149) == 0) calm_mode = ~calm_mode;
      end
      in_tvalid <= drv_next;
    end
  end

  // ---------------------------------------------------------------- monitor
  int           hold_cycles = 0;
  bit           long_hold_done = 1'b0;
  parse_event_t mon_got, mon_want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        events_seen++;
        mon_got = {out_tuser, out_tdata[1:0], out_tdata[17:2], out_tdata[25:18],
                   out_tdata[26], out_tdata[29:27], out_tdata[31:30], out_tdata[32]};
        if (expected_events.size() == 0) begin
          $error("unexpected result word: event %0d", mon_got.ev);
          mismatches++;
        end else begin
          mon_want = expected_events.pop_front();
          if (mon_got.ev != mon_want.ev) begin
            $error("event_res: expected %0d, got %0d", mon_want.ev, mon_got.ev); mismatches++;
          end
          if (mon_got.bank != mon_want.bank) begin
            $error("bank: expected %0d, got %0d", mon_want.bank, mon_got.bank); mismatches++;
          end
          if (mon_got.addr != mon_want.addr) begin
            $error("address: expected %0h, got %0h", mon_want.addr, mon_got.addr); mismatches++;
          end
          if (mon_got.data != mon_want.data) begin
            $error("data_out: expected %0h, got %0h", mon_want.data, mon_got.data); mismatches++;
          end
          if (mon_got.match != mon_want.match) begin
            $error("crc_match: expected %0d, got %0d", mon_want.match, mon_got.match);
            mismatches++;
          end
          if (mon_got.err != mon_want.err) begin
            $error("error_code: expected %0d, got %0d", mon_want.err, mon_got.err); mismatches++;
          end
          if (mon_got.freq != mon_want.freq) begin
            $error("freq_setting: expected %0d, got %0d", mon_want.freq, mon_got.freq);
            mismatches++;
          end
          if (mon_got.boot != mon_want.boot) begin
            $error("warmboot: expected %0d, got %0d", mon_want.boot, mon_got.boot); mismatches++;
          end
        end
      end
      // one long hold-off once traffic is flowing, otherwise random stalls
      if (hold_cycles > 0) hold_cycles--;
      else if (!long_hold_done && events_seen >= 150) begin
        hold_cycles    = 80;
        long_hold_done = 1'b1;
      end else hold_cycles = pick_gap();
      out_tready <= (hold_cycles == 0);
    end
  end

  // ---------------------------------------------------------------- stimulus and end
  initial begin
    // directed: noise and preamble, every command, extremes, special cases
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h7E);
    push_byte(8'h7E); push_byte(8'hAA); push_byte(8'h99); push_byte(8'h7E);
    push_comment(0);
    push_cmd(cbp_pkg::CMD_BANK, 16'd3);
    push_cmd(cbp_pkg::CMD_FREQ, 16'd2);
    push_cmd(cbp_pkg::CMD_BOOT, 16'h0020);
    push_crc_check(1'b1);
    push_write(1'b1);                 // bram size still zero: empty write
    push_cmd(cbp_pkg::CMD_ROW, 16'd3);
    push_cmd(cbp_pkg::CMD_COL, 16'd16);
    push_write(1'b0);
    push_cmd(cbp_pkg::CMD_ROW, 16'd1);
    push_cmd(cbp_pkg::CMD_COL, 16'd24);
    push_write(1'b1);
    push_cmd(cbp_pkg::CMD_PTR, 16'h0080);
    push_write(1'b1);
    push_cmd(cbp_pkg::CMD_PTR, 16'h0000);
    push_cmd(cbp_pkg::CMD_CTRL, 16'(cbp_pkg::CTL_CRCRST));
    push_crc_check(1'b0);
    push_cmd(cbp_pkg::CMD_BOOT, 16'h0000);
    push_comment(5);
    push_pause();
    // random well-formed commands with random content
    while (byte_queue.size() < 1600) begin
      push_random_command();
      if ($urandom_range(0, 99) == 0) push_pause();
    end
    push_ending();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_events.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("run covered %0d input words and %0d result words, ending in one stop case",
             words_taken, events_seen);
    if (mismatches == 0) begin
      $display("** config_bitstream_parser: PASSED **");
    end else begin
      $display("** config_bitstream_parser: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("** config_bitstream_parser: FAILED **");
    $finish;
  end

endmodule
